[design/fdd_pkg.sv]
// Shared types and constants for the float to decimal digit streamer.
package fdd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_BITS = 23;
  localparam int unsigned SIG_W     = FRAC_BITS + 1;
  localparam int unsigned EXP_W     = 8;
  localparam int unsigned NDIGITS   = 8;
  localparam int unsigned BCD_W     = 4 * NDIGITS;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned NDIG_W    = 4;
  localparam int unsigned SYM_W     = 4;
  localparam int unsigned TDATA_W   = 8;

  localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;
  localparam logic [EXP_W-1:0] EXP_MAX  = 8'd150;  // bias plus fraction bits

  localparam logic [SYM_W-1:0] SYM_ZERO  = 4'd0;
  localparam logic [SYM_W-1:0] SYM_MINUS = 4'd10;
  localparam logic [SYM_W-1:0] SYM_POINT = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OOR,
    ST_CONV,
    ST_SIGN,
    ST_TRIM,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_e;

  typedef enum logic [2:0] {
    SEL_OOR,
    SEL_MINUS,
    SEL_INT,
    SEL_POINT,
    SEL_FRAC
  } sym_sel_e;

  typedef struct packed {
    logic     load;
    logic     dd_step;
    logic     bcd_shift;
    logic     frac_step;
    logic     emit;
    sym_sel_e sel;
    logic     last;
    logic     oor;
  } cmd_t;

  typedef struct packed {
    logic in_oor;
    logic sign;
    logic conv_done;
    logic top_zero;
    logic ndig_one;
    logic frac_zero;
    logic frac_next_zero;
    logic out_free;
  } sts_t;

endpackage

[design/fdd_ctrl.sv]
// Controller state machine sequencing conversion and symbol output.
module fdd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fdd_pkg::sts_t sts_i,
  output fdd_pkg::cmd_t cmd_o
);

  fdd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_oor ? fdd_pkg::ST_OOR : fdd_pkg::ST_CONV;
        end
      end
      fdd_pkg::ST_OOR: begin
        if (sts_i.out_free) state_d = fdd_pkg::ST_IDLE;
      end
      fdd_pkg::ST_CONV: begin
        if (sts_i.conv_done) begin
          state_d = sts_i.sign ? fdd_pkg::ST_SIGN : fdd_pkg::ST_TRIM;
        end
      end
      fdd_pkg::ST_SIGN: begin
        if (sts_i.out_free) state_d = fdd_pkg::ST_TRIM;
      end
      fdd_pkg::ST_TRIM: begin
        if (!sts_i.top_zero) state_d = fdd_pkg::ST_INT;
      end
      fdd_pkg::ST_INT: begin
        if (sts_i.out_free && sts_i.ndig_one) begin
          state_d = sts_i.frac_zero ? fdd_pkg::ST_IDLE : fdd_pkg::ST_POINT;
        end
      end
      fdd_pkg::ST_POINT: begin
        if (sts_i.out_free) state_d = fdd_pkg::ST_FRAC;
      end
      fdd_pkg::ST_FRAC: begin
        if (sts_i.out_free && sts_i.frac_next_zero) state_d = fdd_pkg::ST_IDLE;
      end
      default: state_d = fdd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = fdd_pkg::SEL_OOR;
    in_ready_o = 1'b0;
    case (state_q)
      fdd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fdd_pkg::ST_OOR: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = fdd_pkg::SEL_OOR;
        cmd_o.last = 1'b1;
        cmd_o.oor  = 1'b1;
      end
      fdd_pkg::ST_CONV: begin
        cmd_o.dd_step = 1'b1;
      end
      fdd_pkg::ST_SIGN: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = fdd_pkg::SEL_MINUS;
      end
      fdd_pkg::ST_TRIM: begin
        cmd_o.bcd_shift = sts_i.top_zero;
      end
      fdd_pkg::ST_INT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.bcd_shift = sts_i.out_free;
        cmd_o.sel       = fdd_pkg::SEL_INT;
        cmd_o.last      = sts_i.ndig_one && sts_i.frac_zero;
      end
      fdd_pkg::ST_POINT: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = fdd_pkg::SEL_POINT;
      end
      fdd_pkg::ST_FRAC: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.frac_step = sts_i.out_free;
        cmd_o.sel       = fdd_pkg::SEL_FRAC;
        cmd_o.last      = sts_i.frac_next_zero;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_trim_not_past_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdd_pkg::ST_TRIM) |-> !sts_i.ndig_one || !sts_i.top_zero)
    else $error("leading zero trim ran past the last digit");

  a_int_after_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdd_pkg::ST_INT) && !$past(state_q == fdd_pkg::ST_INT)
      |-> $past(state_q == fdd_pkg::ST_TRIM))
    else $error("integer digits entered without trim");

  a_point_needs_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdd_pkg::ST_POINT) |-> !sts_i.frac_zero)
    else $error("point emitted with zero fraction");

endmodule

[design/fdd_dp.sv]
// Datapath: double-dabble converter, fraction times ten step, output register.
module fdd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fdd_pkg::WORD_W-1:0]    in_word_i,
  input  fdd_pkg::cmd_t                 cmd_i,
  output fdd_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fdd_pkg::SYM_W-1:0]     out_sym_o,
  output logic                          out_last_o,
  output logic                          out_oor_o
);

  localparam int unsigned SigW  = fdd_pkg::SIG_W;
  localparam int unsigned FracW = fdd_pkg::FRAC_BITS;
  localparam int unsigned BcdW  = fdd_pkg::BCD_W;
  localparam int unsigned ProdW = FracW + 4;

  logic [fdd_pkg::EXP_W-1:0]  exp_in;
  logic [fdd_pkg::EXP_W-1:0]  p_full;
  logic                       sign_q;
  logic [SigW-1:0]            sr_q, sr_d;
  logic [BcdW-1:0]            bcd_q, bcd_d, bcd_adj;
  logic [fdd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [fdd_pkg::NDIG_W-1:0] ndig_q, ndig_d;
  logic [FracW-1:0]           frac;
  logic [ProdW-1:0]           prod;
  logic [fdd_pkg::SYM_W-1:0]  sym;
  logic                       out_valid_q;
  logic [fdd_pkg::SYM_W-1:0]  out_sym_q;
  logic                       out_last_q;
  logic                       out_oor_q;

  assign exp_in = in_word_i[fdd_pkg::WORD_W-2 -: fdd_pkg::EXP_W];
  assign p_full = exp_in - fdd_pkg::EXP_BIAS;

  // after conversion the fraction sits left-aligned in sr_q[SigW-1:1]
  assign frac = sr_q[SigW-1:1];
  assign prod = {frac, 3'b000} + {2'b00, frac, 1'b0};

  always_comb begin
    for (int i = 0; i < fdd_pkg::NDIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    sr_d   = sr_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    ndig_d = ndig_q;
    if (cmd_i.load) begin
      sr_d   = {1'b1, in_word_i[FracW-1:0]};
      bcd_d  = '0;
      cnt_d  = p_full[fdd_pkg::CNT_W-1:0];
      ndig_d = fdd_pkg::NDIG_W'(fdd_pkg::NDIGITS);
    end else if (cmd_i.dd_step) begin
      bcd_d = {bcd_adj[BcdW-2:0], sr_q[SigW-1]};
      sr_d  = {sr_q[SigW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.bcd_shift) begin
      bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
      ndig_d = ndig_q - 1'b1;
    end else if (cmd_i.frac_step) begin
      sr_d = {prod[FracW-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q   <= sr_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    if (cmd_i.load) sign_q <= in_word_i[fdd_pkg::WORD_W-1];
  end

  always_comb begin
    case (cmd_i.sel)
      fdd_pkg::SEL_OOR:   sym = fdd_pkg::SYM_ZERO;
      fdd_pkg::SEL_MINUS: sym = fdd_pkg::SYM_MINUS;
      fdd_pkg::SEL_INT:   sym = bcd_q[BcdW-1 -: 4];
      fdd_pkg::SEL_POINT: sym = fdd_pkg::SYM_POINT;
      fdd_pkg::SEL_FRAC:  sym = prod[ProdW-1 -: 4];
      default:            sym = fdd_pkg::SYM_ZERO;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sym_q  <= sym;
      out_last_q <= cmd_i.last;
      out_oor_q  <= cmd_i.oor;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sym_o   = out_sym_q;
  assign out_last_o  = out_last_q;
  assign out_oor_o   = out_oor_q;

  assign sts_o.in_oor         = (exp_in < fdd_pkg::EXP_BIAS) || (exp_in > fdd_pkg::EXP_MAX);
  assign sts_o.sign           = sign_q;
  assign sts_o.conv_done      = (cnt_q == '0);
  assign sts_o.top_zero       = (bcd_q[BcdW-1 -: 4] == 4'd0);
  assign sts_o.ndig_one       = (ndig_q == fdd_pkg::NDIG_W'(1));
  assign sts_o.frac_zero      = (frac == '0);
  assign sts_o.frac_next_zero = (prod[FracW-1:0] == '0);
  assign sts_o.out_free       = !out_valid_q || out_ready_i;

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("word emitted over an untaken word");

  a_oor_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oor_q |-> out_last_q && (out_sym_q == fdd_pkg::SYM_ZERO))
    else $error("out of range word not a lone zero");

  a_frac_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.frac_step |-> !sts_o.frac_zero)
    else $error("fraction step on zero fraction");

  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && (cmd_i.sel == fdd_pkg::SEL_INT || cmd_i.sel == fdd_pkg::SEL_FRAC)
      |-> sym <= 4'd9)
    else $error("digit out of decimal range");

endmodule

[design/float_to_decimal_digits.sv]
// Top level: IEEE 754 single word in, stream of decimal symbols out.
//
//  channel   dir  tdata                     tlast        tuser
//  s_axis    in   [31:0] float_bits         -            -
//  m_axis    out  [3:0] symbol, [7:4] zero  last symbol  out_of_range
//
// One word at a time: an accept step, double-dabble steps (one bit of the
// integer part each), a trim step per leading zero of the eight digits,
// then the output symbols one by one.
// Out-of-range exponents give a single flagged word.
// Reset clears the controller and the output valid; a stalled m_axis holds
// the output word and pauses the sequencer in its emitting states.
module float_to_decimal_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [fdd_pkg::WORD_W-1:0]    s_axis_tdata_i,   // [31:0] float_bits
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [fdd_pkg::TDATA_W-1:0]   m_axis_tdata_o,   // [3:0] symbol, [7:4] zero
  output logic                          m_axis_tlast_o,   // last
  output logic                          m_axis_tuser_o    // [0] out_of_range
);

  fdd_pkg::cmd_t             cmd;
  fdd_pkg::sts_t             sts;
  logic [fdd_pkg::SYM_W-1:0] sym;

  fdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fdd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_sym_o   (sym),
    .out_last_o  (m_axis_tlast_o),
    .out_oor_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(fdd_pkg::TDATA_W - fdd_pkg::SYM_W){1'b0}}, sym};

endmodule
